@@ design/fab_pkg.sv @@
// Shared types and constants of the first-fit heap allocator.
package fab_pkg;

   localparam int REQ_W    = 16;           // request, offset and result field width
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 16;           // data size of one block record
   localparam int OFS_W    = SIZE_W + 1;   // running header offset, holds the whole heap
   localparam int WIDE_W   = OFS_W + 1;    // split test headroom

   localparam int MIN_SPLIT_DATA = 4;      // smallest data area worth splitting off
   localparam int ALIGN_ADD      = 3;
   localparam logic [OFS_W-1:0] ALIGN_MASK = ~OFS_W'(3);

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NULL      = 2'd2;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              used;
   } rec_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ALLOC_SCAN,
      ST_ALLOC_SHIFT,
      ST_REL_SCAN
   } state_type;

endpackage

@@ design/fab_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module fab_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16384,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/first_fit_heap_allocator.sv @@
// First-fit heap allocator: one item is taken while busy is low and its result is strobed
// on rsp_valid for exactly one cycle, which the receiver must take. Block records live in
// one memory read one record per cycle, and that read port sets the time per item. A null
// request (zero bytes, or release of offset 0) is answered in the cycle after it is taken.
// An allocate scans records until the first fit; when the block is split the records above
// it are moved up one place. A release walks all records once, merging free neighbours as
// it goes. After reset the block stays busy in ST_INIT while the first record is written.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES    = 65536,
   parameter int HEADER_BYTES  = 12,
   parameter int GRANULE_SLOTS = 16384
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [fab_pkg::REQ_W-1:0]     req_request_bytes,
   input  logic [fab_pkg::REQ_W-1:0]     req_release_offset,
   output logic                          rsp_valid,
   output logic [fab_pkg::REQ_W-1:0]     rsp_data_offset,
   output logic [fab_pkg::STATUS_W-1:0]  rsp_status
);

   import fab_pkg::*;

   localparam int IW = $clog2(GRANULE_SLOTS);
   localparam int CW = $clog2(GRANULE_SLOTS + 1);
   localparam int RW = $bits(rec_type);

   localparam logic [CW-1:0]     SLOTS_C   = CW'(GRANULE_SLOTS);
   localparam logic [OFS_W-1:0]  HDR_C     = OFS_W'(HEADER_BYTES);
   localparam logic [SIZE_W-1:0] HDR_S     = SIZE_W'(HEADER_BYTES);
   localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);

   state_type state_ff, state_in;

   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic              dvalid_ff, dvalid_in;
   logic [IW-1:0]     dix_ff, dix_in;
   logic [OFS_W-1:0]  hdr_ff, hdr_in;
   logic [OFS_W-1:0]  need_ff, need_in;
   logic [REQ_W-1:0]  off_ff, off_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [REQ_W-1:0]  res_ofs_ff, res_ofs_in;
   logic [IW-1:0]     wr_idx_ff, wr_idx_in;
   rec_type           pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [REQ_W-1:0]  rsp_ofs_ff, rsp_ofs_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   rec_type       mem_wr_data;
   logic          mem_rd_en;
   logic [IW-1:0] mem_rd_addr;
   logic [RW-1:0] mem_rd_data;
   rec_type       rd_rec;

   logic              accept, null_req, issue;
   logic [OFS_W-1:0]  cur_end, hdr_next;
   logic              fit, split, hit, scan_end, shift_more;
   rec_type           cur_rec;

   fab_ram #(
      .WIDTH (RW),
      .DEPTH (GRANULE_SLOTS)
   ) u_records (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_rec   = rec_type'(mem_rd_data);
   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign null_req = (req_op == OP_ALLOC) ? (req_request_bytes == '0)
                                          : (req_release_offset == '0);

   // data offset of the record in the data stage and header offset of the one after it
   assign cur_end  = hdr_ff + HDR_C;
   assign hdr_next = cur_end + OFS_W'(rd_rec.size);

   assign fit   = !rd_rec.used && (OFS_W'(rd_rec.size) >= need_ff);
   assign split = (WIDE_W'(rd_rec.size) >= WIDE_W'(need_ff) + WIDE_W'(HEADER_BYTES)
                   + WIDE_W'(MIN_SPLIT_DATA)) && (count_ff < SLOTS_C);
   assign hit   = (cur_end == OFS_W'(off_ff));

   assign cur_rec = '{size: rd_rec.size, used: rd_rec.used && !hit};

   assign scan_end   = !dvalid_ff && (rd_idx_ff == count_ff);
   assign shift_more = (rd_idx_ff > CW'(idx_ff));

   // read issue: one record per cycle, upward for scans, downward for the shift
   always_comb begin
      unique case (state_ff)
         ST_ALLOC_SCAN:  issue = (rd_idx_ff < count_ff) && !(dvalid_ff && fit);
         ST_ALLOC_SHIFT: issue = shift_more;
         ST_REL_SCAN:    issue = (rd_idx_ff < count_ff);
         default:        issue = 1'b0;
      endcase
   end

   assign mem_rd_en   = issue;
   assign mem_rd_addr = rd_idx_ff[IW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && !null_req) begin
               state_in = (req_op == OP_ALLOC) ? ST_ALLOC_SCAN : ST_REL_SCAN;
            end
         end
         ST_ALLOC_SCAN: begin
            priority if (dvalid_ff && fit) begin
               state_in = split ? ST_ALLOC_SHIFT : ST_IDLE;
            end else if (scan_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_ALLOC_SHIFT: begin
            if (!dvalid_ff && !shift_more) begin
               state_in = ST_IDLE;
            end
         end
         ST_REL_SCAN: begin
            if (scan_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // datapath and memory writes
   always_comb begin
      count_in      = count_ff;
      rd_idx_in     = issue ? ((state_ff == ST_ALLOC_SHIFT) ? rd_idx_ff - 1'b1
                                                            : rd_idx_ff + 1'b1)
                            : rd_idx_ff;
      dvalid_in     = issue;
      dix_in        = rd_idx_ff[IW-1:0];
      hdr_in        = hdr_ff;
      need_in       = need_ff;
      off_in        = off_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      res_ofs_in    = res_ofs_ff;
      wr_idx_in     = wr_idx_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      found_in      = found_ff;
      rsp_valid_in  = 1'b0;
      rsp_ofs_in    = '0;
      rsp_status_in = STATUS_OK;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = dix_ff;
      mem_wr_data   = rd_rec;

      unique case (state_ff)
         ST_INIT: begin
            mem_wr_en        = 1'b1;
            mem_wr_addr      = '0;
            mem_wr_data.size = INIT_SIZE;
            mem_wr_data.used = 1'b0;
            count_in         = CW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               rd_idx_in     = '0;
               hdr_in        = '0;
               wr_idx_in     = '0;
               pend_valid_in = 1'b0;
               found_in      = 1'b0;
               need_in       = (OFS_W'(req_request_bytes) + OFS_W'(ALIGN_ADD)) & ALIGN_MASK;
               off_in        = req_release_offset;
               if (null_req) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NULL;
               end
            end
         end
         ST_ALLOC_SCAN: begin
            priority if (dvalid_ff && fit) begin
               mem_wr_en        = 1'b1;
               mem_wr_data.used = 1'b1;
               if (split) begin
                  // keep the request size, then move the records above up one place
                  mem_wr_data.size = need_ff[SIZE_W-1:0];
                  idx_in           = dix_ff;
                  rem_in           = rd_rec.size - need_ff[SIZE_W-1:0] - HDR_S;
                  res_ofs_in       = cur_end[REQ_W-1:0];
                  rd_idx_in        = count_ff - 1'b1;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_ofs_in    = cur_end[REQ_W-1:0];
                  rsp_status_in = STATUS_OK;
               end
            end else if (dvalid_ff) begin
               hdr_in = hdr_next;
            end else if (scan_end) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_MEMORY;
            end
         end
         ST_ALLOC_SHIFT: begin
            if (dvalid_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = dix_ff + 1'b1;
            end else if (!shift_more) begin
               mem_wr_en        = 1'b1;
               mem_wr_addr      = idx_ff + 1'b1;
               mem_wr_data.size = rem_ff;
               mem_wr_data.used = 1'b0;
               count_in         = count_ff + 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_ofs_in       = res_ofs_ff;
               rsp_status_in    = STATUS_OK;
            end
         end
         ST_REL_SCAN: begin
            // compact in one pass: merge free neighbours into the held record
            if (dvalid_ff) begin
               hdr_in   = hdr_next;
               found_in = found_ff || hit;
               priority if (!pend_valid_ff) begin
                  pend_in       = cur_rec;
                  pend_valid_in = 1'b1;
               end else if (!pend_ff.used && !cur_rec.used) begin
                  pend_in.size = pend_ff.size + HDR_S + cur_rec.size;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wr_idx_ff;
                  mem_wr_data = pend_ff;
                  wr_idx_in   = wr_idx_ff + 1'b1;
                  pend_in     = cur_rec;
               end
            end else if (scan_end) begin
               mem_wr_en     = 1'b1;
               mem_wr_addr   = wr_idx_ff;
               mem_wr_data   = pend_ff;
               count_in      = CW'(wr_idx_ff) + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_ff ? STATUS_OK : STATUS_NULL;
            end
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         count_ff     <= CW'(1);
         dvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      dix_ff        <= dix_in;
      hdr_ff        <= hdr_in;
      need_ff       <= need_in;
      off_ff        <= off_in;
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      res_ofs_ff    <= res_ofs_in;
      wr_idx_ff     <= wr_idx_in;
      pend_ff       <= pend_in;
      pend_valid_ff <= pend_valid_in;
      found_ff      <= found_in;
      rsp_ofs_ff    <= rsp_ofs_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_offset = rsp_ofs_ff;
   assign rsp_status      = rsp_status_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= SLOTS_C))
      else $error("record count out of range");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted item neither in work nor answered");

   a_fail_no_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_data_offset == '0))
      else $error("failed item carries an offset");

   a_shift_above_split: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ALLOC_SHIFT) && mem_wr_en) |-> (mem_wr_addr > idx_ff))
      else $error("shift write at or below split record");

endmodule
